// ===== rtl/rgb_led_linear_fade_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Fade engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_LINEAR_FADE_ENGINE_CORE_DEFINES_SVH
`define RGB_LED_LINEAR_FADE_ENGINE_CORE_DEFINES_SVH

// Condition holds at every edge.
`define RLFE_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RLFE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RLFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rlfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Fade engine package
// Operation codes, sequencer states and shared constants.
// ----------------------------------------------------------------------------
package rlfe_pkg;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_FADE      = 3'd1,
    OP_FADE_FROM = 3'd2,
    OP_QUEUE     = 3'd3,
    OP_START     = 3'd4,
    OP_TICK      = 3'd5,
    OP_CLEAR     = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_RESULT,
    ST_FLUSH
  } state_t;

  // Packed colour, element 0 red, 1 green, 2 blue.
  typedef logic [2:0][7:0] rgb_t;

  localparam logic [11:0] LEN_NUM    = 12'd4095;
  localparam int          RESULT_CAP = 8;
  localparam logic [3:0]  LEN_STEPS  = 4'd12;
  localparam logic [3:0]  MIX_STEPS  = 4'd8;

endpackage

// ===== rtl/rgb_led_linear_fade_engine_core.sv =====
// ----------------------------------------------------------------------------
// Linear RGB LED fade engine
// Per-LED colour fades driven by commands and ticks, one shared divider.
// ----------------------------------------------------------------------------
// Each LED keeps start, current and target colours plus a fade length and
// progress and one queued fade. Commands set a colour at once, start a fade,
// queue one, start all queued fades, tick, or clear. The block takes one
// command at a time and holds in_stall high until it is done. A shared
// restoring divider (one quotient bit per cycle) does all division: a fade
// command first derives its length from speed in the divider. A tick walks
// the LEDs in turn, idle ones one per cycle; an LED still mid-fade takes
// a multiply step, a divide and an add step for each of its three channels.
// Set results (also any zero-speed fade or queue), explicit-start fade and
// tick results leave through an output register, with one result held back
// so the final one can carry last and, for a tick, refresh.
// ----------------------------------------------------------------------------
`include "rgb_led_linear_fade_engine_core_defines.svh"

module rgb_led_linear_fade_engine_core #(
  parameter int LED_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [3:0] led_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] start_red,
  input  logic [7:0] start_green,
  input  logic [7:0] start_blue,
  input  logic [7:0] speed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       refresh,
  output logic       last
);

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CW = $clog2(LED_COUNT + 1);

  // Per-LED state, held in flops
  rlfe_pkg::rgb_t start_c [LED_COUNT];
  rlfe_pkg::rgb_t cur_c   [LED_COUNT];
  rlfe_pkg::rgb_t tgt_c   [LED_COUNT];
  logic [14:0]    flen    [LED_COUNT];
  logic [14:0]    fprog   [LED_COUNT];
  logic [14:0]    qlen    [LED_COUNT];
  logic [LED_COUNT-1:0] qflag;

  // Captured command
  rlfe_pkg::op_t  op_q;
  logic [IW-1:0]  idx_q;
  rlfe_pkg::rgb_t col_q;
  rlfe_pkg::rgb_t st_q;

  // Sequencer
  rlfe_pkg::state_t state, state_next;
  logic [CW-1:0] scan;
  logic [1:0]    ch;
  logic [3:0]    n_res;
  logic [14:0]   p_q;

  // Shared divider
  logic [15:0] div_rem;
  logic [23:0] div_dq;
  logic [14:0] div_den;
  logic [3:0]  div_steps;
  logic        div_neg;

  // Held-back result
  logic           pend_v;
  logic [IW-1:0]  pend_idx;
  rlfe_pkg::rgb_t pend_col;

  // Combinational
  rlfe_pkg::op_t  op_in;
  rlfe_pkg::rgb_t col_in, st_in;
  logic [IW+3:0]  idx_wide;
  logic [IW-1:0]  idx_in;
  logic           in_range;
  logic           accept;
  logic [IW-1:0]  si;
  logic           scan_end;
  logic [14:0]    cur_len;
  logic [14:0]    p_inc;
  logic           fade_done;
  logic signed [8:0]  diff;
  logic signed [24:0] prod;
  logic [24:0]    prod_abs;
  logic [15:0]    trial;
  logic           ge;
  logic [15:0]    rem_next;
  logic [7:0]     addend;
  logic [7:0]     mix;
  logic [14:0]    len_val;
  logic           out_free;
  logic           out_load;
  logic           res_take;
  logic           is_tick;
  logic [IW+2:0]  oidx_wide;

  assign op_in    = rlfe_pkg::op_t'(operation);
  assign col_in   = {blue, green, red};
  assign st_in    = {start_blue, start_green, start_red};
  assign idx_wide = {{IW{1'b0}}, led_index};
  assign idx_in   = idx_wide[IW-1:0];
  assign in_range = ({3'b000, led_index} < 7'(LED_COUNT));
  assign is_tick  = (op_q == rlfe_pkg::OP_TICK);

  assign si        = scan[IW-1:0];
  assign scan_end  = (scan == CW'(LED_COUNT));
  assign cur_len   = flen[si];
  assign p_inc     = fprog[si] + 15'd1;
  assign fade_done = (p_inc >= cur_len);

  // (target - start) * progress, magnitude taken for the divider
  assign diff     = $signed({1'b0, tgt_c[si][ch]}) - $signed({1'b0, start_c[si][ch]});
  assign prod     = diff * $signed({1'b0, p_q});
  assign prod_abs = prod[24] ? -prod : prod;

  // One restoring-division step
  assign trial    = {div_rem[14:0], div_dq[23]};
  assign ge       = (trial >= {1'b0, div_den});
  assign rem_next = ge ? (trial - {1'b0, div_den}) : trial;

  // Quotient truncates toward zero: apply sign after dividing the magnitude
  assign addend  = div_neg ? (~div_dq[7:0] + 8'd1) : div_dq[7:0];
  assign mix     = start_c[si][ch] + addend;
  assign len_val = {div_dq[11:0], 3'b000};

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rlfe_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_in)
            rlfe_pkg::OP_SET, rlfe_pkg::OP_FADE,
            rlfe_pkg::OP_FADE_FROM, rlfe_pkg::OP_QUEUE: begin
              if (!in_range) state_next = rlfe_pkg::ST_IDLE;
              else if (op_in == rlfe_pkg::OP_SET || speed == 8'd0)
                state_next = rlfe_pkg::ST_FLUSH;
              else state_next = rlfe_pkg::ST_DIV;
            end
            rlfe_pkg::OP_TICK: state_next = rlfe_pkg::ST_SCAN;
            default: state_next = rlfe_pkg::ST_IDLE;
          endcase
        end
      end
      rlfe_pkg::ST_DIV: begin
        if (div_steps == 4'd1)
          state_next = is_tick ? rlfe_pkg::ST_ADD : rlfe_pkg::ST_APPLY;
      end
      rlfe_pkg::ST_APPLY: begin
        state_next = (op_q == rlfe_pkg::OP_FADE_FROM) ? rlfe_pkg::ST_FLUSH
                                                      : rlfe_pkg::ST_IDLE;
      end
      rlfe_pkg::ST_SCAN: begin
        if (scan_end) state_next = pend_v ? rlfe_pkg::ST_FLUSH : rlfe_pkg::ST_IDLE;
        else if (cur_len == 15'd0) state_next = rlfe_pkg::ST_SCAN;
        else if (fade_done) state_next = rlfe_pkg::ST_RESULT;
        else state_next = rlfe_pkg::ST_MUL;
      end
      rlfe_pkg::ST_MUL: state_next = rlfe_pkg::ST_DIV;
      rlfe_pkg::ST_ADD: begin
        state_next = (ch == 2'd2) ? rlfe_pkg::ST_RESULT : rlfe_pkg::ST_MUL;
      end
      rlfe_pkg::ST_RESULT: begin
        if (n_res < 4'(rlfe_pkg::RESULT_CAP) && pend_v && !out_free)
          state_next = rlfe_pkg::ST_RESULT;
        else state_next = rlfe_pkg::ST_SCAN;
      end
      rlfe_pkg::ST_FLUSH: begin
        if (out_free) state_next = rlfe_pkg::ST_IDLE;
      end
      default: state_next = rlfe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = (state != rlfe_pkg::ST_IDLE);
    accept   = in_valid && (state == rlfe_pkg::ST_IDLE);
    res_take = (state == rlfe_pkg::ST_RESULT) && (n_res < 4'(rlfe_pkg::RESULT_CAP))
               && (!pend_v || out_free);
    out_load = ((state == rlfe_pkg::ST_FLUSH) && out_free) || (res_take && pend_v);
  end

  // Sequencer, divider and result path
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlfe_pkg::ST_IDLE;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      n_res     <= 4'd0;
      scan      <= '0;
      ch        <= 2'd0;
    end else begin
      state <= state_next;

      // Drop the output once taken, reload when the sequencer pushes.
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        rlfe_pkg::ST_IDLE: begin
          if (accept) begin
            op_q  <= op_in;
            idx_q <= idx_in;
            col_q <= col_in;
            st_q  <= st_in;
            scan  <= '0;
            n_res <= 4'd0;
            // Length divider: 4095 / speed, 12 quotient bits
            div_rem   <= 16'd0;
            div_dq    <= {rlfe_pkg::LEN_NUM, 12'd0};
            div_den   <= {7'd0, speed};
            div_steps <= rlfe_pkg::LEN_STEPS;
            div_neg   <= 1'b0;
            pend_idx  <= idx_in;
            pend_col  <= col_in;
            if (op_in <= rlfe_pkg::OP_QUEUE && in_range
                && (op_in == rlfe_pkg::OP_SET || speed == 8'd0))
              pend_v <= 1'b1;
          end
        end
        rlfe_pkg::ST_DIV: begin
          div_rem   <= rem_next;
          div_dq    <= {div_dq[22:0], ge};
          div_steps <= div_steps - 4'd1;
        end
        rlfe_pkg::ST_APPLY: begin
          if (op_q == rlfe_pkg::OP_FADE_FROM) begin
            pend_v   <= 1'b1;
            pend_idx <= idx_q;
            pend_col <= st_q;
          end
        end
        rlfe_pkg::ST_SCAN: begin
          if (!scan_end) begin
            if (cur_len == 15'd0) scan <= scan + CW'(1);
            else begin
              p_q <= p_inc;
              ch  <= 2'd0;
            end
          end
        end
        rlfe_pkg::ST_MUL: begin
          div_rem   <= prod_abs[23:8];
          div_dq    <= {prod_abs[7:0], 16'd0};
          div_den   <= cur_len;
          div_steps <= rlfe_pkg::MIX_STEPS;
          div_neg   <= prod[24];
        end
        rlfe_pkg::ST_ADD: ch <= ch + 2'd1;
        rlfe_pkg::ST_RESULT: begin
          if (state_next == rlfe_pkg::ST_SCAN) scan <= scan + CW'(1);
          if (res_take) begin
            pend_v   <= 1'b1;
            pend_idx <= si;
            pend_col <= cur_c[si];
            n_res    <= n_res + 4'd1;
          end
        end
        rlfe_pkg::ST_FLUSH: begin
          if (out_free) pend_v <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output register payload
  assign oidx_wide = {3'b000, pend_idx};
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= oidx_wide[2:0];
      out_red   <= pend_col[0];
      out_green <= pend_col[1];
      out_blue  <= pend_col[2];
      last      <= (state == rlfe_pkg::ST_FLUSH);
      refresh   <= (state == rlfe_pkg::ST_FLUSH) && is_tick;
    end
  end

  // LED state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        start_c[i] <= '0;
        cur_c[i]   <= '0;
        tgt_c[i]   <= '0;
        flen[i]    <= '0;
        fprog[i]   <= '0;
        qlen[i]    <= '0;
      end
      qflag <= '0;
    end else begin
      case (state)
        rlfe_pkg::ST_IDLE: begin
          if (accept) begin
            case (op_in)
              rlfe_pkg::OP_SET, rlfe_pkg::OP_FADE,
              rlfe_pkg::OP_FADE_FROM, rlfe_pkg::OP_QUEUE: begin
                // Set at once
                if (in_range && (op_in == rlfe_pkg::OP_SET || speed == 8'd0)) begin
                  start_c[idx_in] <= col_in;
                  cur_c[idx_in]   <= col_in;
                  tgt_c[idx_in]   <= col_in;
                  flen[idx_in]    <= '0;
                  qflag[idx_in]   <= 1'b0;
                end
              end
              rlfe_pkg::OP_START: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                  if (qflag[i]) begin
                    start_c[i] <= cur_c[i];
                    fprog[i]   <= '0;
                    flen[i]    <= qlen[i];
                    qflag[i]   <= 1'b0;
                  end
                end
              end
              rlfe_pkg::OP_CLEAR: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                  flen[i]  <= '0;
                  fprog[i] <= '0;
                  qlen[i]  <= '0;
                end
                qflag <= '0;
              end
              default: ;
            endcase
          end
        end
        rlfe_pkg::ST_APPLY: begin
          case (op_q)
            rlfe_pkg::OP_FADE: begin
              start_c[idx_q] <= cur_c[idx_q];
              tgt_c[idx_q]   <= col_q;
              flen[idx_q]    <= len_val;
              fprog[idx_q]   <= '0;
              qflag[idx_q]   <= 1'b0;
            end
            rlfe_pkg::OP_FADE_FROM: begin
              start_c[idx_q] <= st_q;
              cur_c[idx_q]   <= st_q;
              tgt_c[idx_q]   <= col_q;
              flen[idx_q]    <= len_val;
              fprog[idx_q]   <= '0;
              qflag[idx_q]   <= 1'b0;
            end
            rlfe_pkg::OP_QUEUE: begin
              // Running fade heads for the new target right away
              tgt_c[idx_q] <= col_q;
              qlen[idx_q]  <= len_val;
              qflag[idx_q] <= 1'b1;
            end
            default: ;
          endcase
        end
        rlfe_pkg::ST_SCAN: begin
          if (!scan_end && cur_len != 15'd0) begin
            if (fade_done) begin
              fprog[si] <= cur_len;
              cur_c[si] <= tgt_c[si];
              flen[si]  <= '0;
            end else begin
              fprog[si] <= p_inc;
            end
          end
        end
        rlfe_pkg::ST_ADD: cur_c[si][ch] <= mix;
        default: ;
      endcase
    end
  end

  `RLFE_ASSERT_IMPLIES(a_idle_no_pend, state == rlfe_pkg::ST_IDLE, !pend_v, "result left behind in idle")
  `RLFE_ASSERT_HOLDS(a_res_cap, n_res <= 4'(rlfe_pkg::RESULT_CAP), "tick result count over cap")
  `RLFE_ASSERT_IMPLIES(a_div_rem, state == rlfe_pkg::ST_DIV, div_rem < 16'(div_den), "divider remainder out of range")
  `RLFE_ASSERT_NEXT(a_flush_out, state == rlfe_pkg::ST_FLUSH && out_free, out_valid && last && !pend_v, "final result not pushed")

endmodule
